// ===== hw/rtl/hcmb_pkg.sv =====
package hcmb_pkg;

   localparam int VRAM_BYTES_DEF      = 8192;
   localparam int WRAM_BANK_BYTES_DEF = 4096;

   localparam int SPRITE_BYTES = 160;
   localparam int UNUSED_BYTES = 96;
   localparam int IO_BYTES     = 128;
   localparam int HRAM_BYTES   = 127;

   localparam logic [15:0] OAM_BASE    = 16'hFE00;
   localparam logic [15:0] UNUSED_BASE = 16'hFEA0;
   localparam logic [15:0] IO_BASE     = 16'hFF00;
   localparam logic [15:0] HRAM_BASE   = 16'hFF80;
   localparam logic [15:0] IE_ADDR     = 16'hFFFF;

   localparam logic [7:0] BYTE_ONES  = 8'hFF;
   localparam logic [7:0] P1_KEEP    = 8'hC0;
   localparam logic [7:0] P1_SEL     = 8'h30;
   localparam logic [7:0] STAT_KEEP  = 8'h83;
   localparam logic [7:0] STAT_WRITE = 8'h7C;

   // cartridge operation codes
   localparam logic [1:0] CART_NONE   = 2'd0;
   localparam logic [1:0] CART_MAPPER = 2'd1;
   localparam logic [1:0] CART_XWRITE = 2'd2;
   localparam logic [1:0] CART_READ   = 2'd3;

   // i/o offsets
   localparam logic [6:0] IO_P1   = 7'h00;
   localparam logic [6:0] IO_SC   = 7'h02;
   localparam logic [6:0] IO_DIV  = 7'h04;
   localparam logic [6:0] IO_TAC  = 7'h07;
   localparam logic [6:0] IO_IF   = 7'h0F;
   localparam logic [6:0] IO_LCDC = 7'h40;
   localparam logic [6:0] IO_STAT = 7'h41;
   localparam logic [6:0] IO_SCY  = 7'h42;
   localparam logic [6:0] IO_SCX  = 7'h43;
   localparam logic [6:0] IO_LY   = 7'h44;
   localparam logic [6:0] IO_LYC  = 7'h45;
   localparam logic [6:0] IO_DMA  = 7'h46;
   localparam logic [6:0] IO_BGP  = 7'h47;
   localparam logic [6:0] IO_OBP0 = 7'h48;
   localparam logic [6:0] IO_OBP1 = 7'h49;
   localparam logic [6:0] IO_WY   = 7'h4A;
   localparam logic [6:0] IO_WX   = 7'h4B;

   localparam int LCD_REGS  = 10;
   localparam int STAT_SLOT = 1;

   typedef enum logic [3:0] {
      RGN_CART, RGN_VRAM, RGN_XRAM, RGN_WRAM, RGN_OAM,
      RGN_UNUSED, RGN_IO, RGN_HRAM, RGN_IE
   } region_type;

   typedef enum logic [2:0] {
      SRC_HOLD, SRC_VRAM, SRC_WRAM, SRC_OAM, SRC_UNUSED, SRC_IO, SRC_HRAM
   } src_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] slot;
   } lcd_sel_type;

   typedef struct packed {
      logic       wr_en;
      logic       is_ie;
      logic [6:0] off;
      logic [7:0] data;
      logic [7:0] keys;
      logic [7:0] line;
   } reg_req_type;

   function automatic region_type decode_region(logic [15:0] addr);
      region_type r;
      priority if (!addr[15])                r = RGN_CART;
      else if (addr[15:13] == 3'b100)        r = RGN_VRAM;
      else if (addr[15:13] == 3'b101)        r = RGN_XRAM;
      else if (addr < OAM_BASE)              r = RGN_WRAM;
      else if (addr < UNUSED_BASE)           r = RGN_OAM;
      else if (addr < IO_BASE)               r = RGN_UNUSED;
      else if (addr < HRAM_BASE)             r = RGN_IO;
      else if (addr != IE_ADDR)              r = RGN_HRAM;
      else                                   r = RGN_IE;
      return r;
   endfunction

   function automatic lcd_sel_type lcd_slot(logic [6:0] off);
      lcd_sel_type s;
      s.hit = 1'b1;
      unique case (off)
         IO_LCDC: s.slot = 4'd0;
         IO_STAT: s.slot = 4'd1;
         IO_SCY:  s.slot = 4'd2;
         IO_SCX:  s.slot = 4'd3;
         IO_LYC:  s.slot = 4'd4;
         IO_BGP:  s.slot = 4'd5;
         IO_OBP0: s.slot = 4'd6;
         IO_OBP1: s.slot = 4'd7;
         IO_WY:   s.slot = 4'd8;
         IO_WX:   s.slot = 4'd9;
         default: begin
            s.hit  = 1'b0;
            s.slot = 4'd0;
         end
      endcase
      return s;
   endfunction

   function automatic logic is_timer(logic [6:0] off);
      return (off >= IO_DIV) && (off <= IO_TAC);
   endfunction

endpackage

// ===== hw/rtl/hcmb_ram.sv =====
module hcmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hcmb_regs.sv =====
module hcmb_regs (
   input  logic                 clock,
   input  logic                 reset,
   input  hcmb_pkg::reg_req_type req,
   output logic                 rd_hit,
   output logic [7:0]           rd_data
);

   logic [7:0] joypad_ff, joypad_in;
   logic [7:0] irq_flags_ff;
   logic [7:0] irq_enable_ff;
   logic [7:0] timer_ff [4];
   logic [7:0] lcd_ff [hcmb_pkg::LCD_REGS];
   logic [3:0] nibble;
   hcmb_pkg::lcd_sel_type lsel;

   assign lsel = hcmb_pkg::lcd_slot(req.off);

   // key nibble picked by the select bits
   always_comb begin
      unique case (req.data[5:4])
         2'b01:   nibble = ~req.keys[7:4];
         2'b10:   nibble = ~req.keys[3:0];
         default: nibble = 4'hF;
      endcase
      joypad_in = (joypad_ff & hcmb_pkg::P1_KEEP) | (req.data & hcmb_pkg::P1_SEL)
                  | {4'h0, nibble};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         joypad_ff     <= '0;
         irq_flags_ff  <= '0;
         irq_enable_ff <= '0;
         for (int i = 0; i < 4; i++) timer_ff[i] <= '0;
         for (int i = 0; i < hcmb_pkg::LCD_REGS; i++) lcd_ff[i] <= '0;
      end else if (req.wr_en) begin
         if (req.is_ie) begin
            irq_enable_ff <= req.data;
         end else if (req.off == hcmb_pkg::IO_P1) begin
            joypad_ff <= joypad_in;
         end else if (req.off == hcmb_pkg::IO_DIV) begin
            timer_ff[0] <= '0;
         end else if (hcmb_pkg::is_timer(req.off)) begin
            timer_ff[req.off[1:0]] <= req.data;
         end else if (req.off == hcmb_pkg::IO_IF) begin
            irq_flags_ff <= req.data;
         end else if (req.off == hcmb_pkg::IO_STAT) begin
            lcd_ff[hcmb_pkg::STAT_SLOT] <= (lcd_ff[hcmb_pkg::STAT_SLOT] & hcmb_pkg::STAT_KEEP)
                                           | (req.data & hcmb_pkg::STAT_WRITE);
         end else if (lsel.hit) begin
            lcd_ff[lsel.slot] <= req.data;
         end
      end
   end

   always_comb begin
      rd_hit  = 1'b1;
      rd_data = '0;
      priority if (req.is_ie)                    rd_data = irq_enable_ff;
      else if (req.off == hcmb_pkg::IO_P1)       rd_data = joypad_ff;
      else if (hcmb_pkg::is_timer(req.off))      rd_data = timer_ff[req.off[1:0]];
      else if (req.off == hcmb_pkg::IO_IF)       rd_data = irq_flags_ff;
      else if (req.off == hcmb_pkg::IO_LY)       rd_data = req.line;
      else if (lsel.hit)                         rd_data = lcd_ff[lsel.slot];
      else                                       rd_hit  = 1'b0;
   end

endmodule

// ===== hw/rtl/handheld_console_memory_bus.sv =====
// a transfer accepted by start shows its result with rsp_valid after it has passed
//   the request register, then the result register
// throughput: one transfer per cycle once busy is low
// reset: synchronous; afterwards busy stays high while all stores are swept
//   clear (i/o bytes to 0xff), then accepts start
// results cannot be stalled: each one is shown for a single cycle
module handheld_console_memory_bus #(
   parameter int VRAM_BYTES      = hcmb_pkg::VRAM_BYTES_DEF,
   parameter int WRAM_BANK_BYTES = hcmb_pkg::WRAM_BANK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_key_states,
   input  logic [7:0]  req_cart_read_data,
   input  logic [7:0]  req_scan_line,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_cart_op,
   output logic [15:0] rsp_cart_address,
   output logic [7:0]  rsp_cart_write_data
);

   localparam int WRAM_BYTES = 2 * WRAM_BANK_BYTES;
   localparam int VRAM_AW    = $clog2(VRAM_BYTES);
   localparam int WRAM_AW    = $clog2(WRAM_BYTES);
   localparam int OAM_AW     = $clog2(hcmb_pkg::SPRITE_BYTES);
   localparam int UNUSED_AW  = $clog2(hcmb_pkg::UNUSED_BYTES);
   localparam int IO_AW      = $clog2(hcmb_pkg::IO_BYTES);
   localparam int HRAM_AW    = $clog2(hcmb_pkg::HRAM_BYTES);
   // the clear sweep runs over the largest store, video ram
   localparam int CNT_W      = VRAM_AW;

   // clear sweep after reset
   logic             clear_ff, clear_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic ext_present_ff;

   // request stage
   logic                 s1_valid_ff;
   hcmb_pkg::src_type    s1_src_ff, s1_src_in;
   logic [7:0]           s1_hold_ff, s1_hold_in;
   logic [1:0]           s1_op_ff, s1_op_in;
   logic [15:0]          s1_addr_ff;
   logic [7:0]           s1_wdata_ff;

   // result stage
   logic        rsp_valid_ff;
   logic [7:0]  rsp_read_ff, rsp_read_in;
   logic [1:0]  rsp_op_ff;
   logic [15:0] rsp_addr_ff;
   logic [7:0]  rsp_wdata_ff;

   logic                  accept;
   logic                  wr;
   hcmb_pkg::region_type  region;
   hcmb_pkg::reg_req_type reg_req;
   logic                  reg_hit;
   logic [7:0]            reg_data;
   logic [7:0]            unused_off;

   // per-store write controls
   logic vram_we, wram_we, oam_we, unused_we, io_we, hram_we;
   logic [VRAM_AW-1:0]   vram_idx, vram_waddr;
   logic [WRAM_AW-1:0]   wram_idx, wram_waddr;
   logic [OAM_AW-1:0]    oam_idx, oam_waddr;
   logic [UNUSED_AW-1:0] unused_idx, unused_waddr;
   logic [IO_AW-1:0]     io_idx, io_waddr;
   logic [HRAM_AW-1:0]   hram_idx, hram_waddr;
   logic [7:0]           ram_wdata, io_wdata;
   logic [7:0] vram_rd, wram_rd, oam_rd, unused_rd, io_rd, hram_rd;

   assign busy   = clear_ff;
   assign accept = start && !clear_ff;
   assign wr     = req_action;
   assign region = hcmb_pkg::decode_region(req_address);

   // store indexes; work ram bank bit and offset sit in the low address bits,
   // and the echo region maps onto the same bits
   assign vram_idx   = VRAM_AW'(req_address[12:0]);
   assign wram_idx   = req_address[WRAM_AW-1:0];
   assign oam_idx    = req_address[OAM_AW-1:0];
   assign unused_off = req_address[7:0] - hcmb_pkg::UNUSED_BASE[7:0];
   assign unused_idx = unused_off[UNUSED_AW-1:0];
   assign io_idx     = req_address[IO_AW-1:0];
   assign hram_idx   = req_address[HRAM_AW-1:0];

   // registers kept in flops
   always_comb begin
      reg_req.wr_en = accept && wr && ((region == hcmb_pkg::RGN_IO) ||
                                       (region == hcmb_pkg::RGN_IE));
      reg_req.is_ie = (region == hcmb_pkg::RGN_IE);
      reg_req.off   = req_address[6:0];
      reg_req.data  = req_write_data;
      reg_req.keys  = req_key_states;
      reg_req.line  = req_scan_line;
   end

   hcmb_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .req     (reg_req),
      .rd_hit  (reg_hit),
      .rd_data (reg_data)
   );

   // clear sweep counter
   always_comb begin
      clear_in = clear_ff;
      cnt_in   = cnt_ff;
      if (clear_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VRAM_BYTES - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   // i/o bytes that live in flops, or are ignored, are never written to the store
   function automatic logic io_plain(logic [6:0] off);
      return !((off == hcmb_pkg::IO_P1) || (off == hcmb_pkg::IO_SC) ||
               (off == hcmb_pkg::IO_LY) || (off == hcmb_pkg::IO_DMA) ||
               (off == hcmb_pkg::IO_IF) || hcmb_pkg::is_timer(off) ||
               hcmb_pkg::lcd_slot(off).hit);
   endfunction

   // store write port: sweep while clearing, bus writes afterwards
   always_comb begin
      ram_wdata = clear_ff ? 8'h00 : req_write_data;
      io_wdata  = clear_ff ? hcmb_pkg::BYTE_ONES : req_write_data;
      if (clear_ff) begin
         vram_we   = 1'b1;
         wram_we   = {1'b0, cnt_ff} < (CNT_W + 1)'(WRAM_BYTES);
         oam_we    = {1'b0, cnt_ff} < (CNT_W + 1)'(hcmb_pkg::SPRITE_BYTES);
         unused_we = {1'b0, cnt_ff} < (CNT_W + 1)'(hcmb_pkg::UNUSED_BYTES);
         io_we     = {1'b0, cnt_ff} < (CNT_W + 1)'(hcmb_pkg::IO_BYTES);
         hram_we   = {1'b0, cnt_ff} < (CNT_W + 1)'(hcmb_pkg::HRAM_BYTES);
         vram_waddr   = cnt_ff[VRAM_AW-1:0];
         wram_waddr   = cnt_ff[WRAM_AW-1:0];
         oam_waddr    = cnt_ff[OAM_AW-1:0];
         unused_waddr = cnt_ff[UNUSED_AW-1:0];
         io_waddr     = cnt_ff[IO_AW-1:0];
         hram_waddr   = cnt_ff[HRAM_AW-1:0];
      end else begin
         vram_we   = accept && wr && (region == hcmb_pkg::RGN_VRAM);
         wram_we   = accept && wr && (region == hcmb_pkg::RGN_WRAM);
         oam_we    = accept && wr && (region == hcmb_pkg::RGN_OAM);
         unused_we = accept && wr && (region == hcmb_pkg::RGN_UNUSED);
         io_we     = accept && wr && (region == hcmb_pkg::RGN_IO) &&
                     io_plain(req_address[6:0]);
         hram_we   = accept && wr && (region == hcmb_pkg::RGN_HRAM);
         vram_waddr   = vram_idx;
         wram_waddr   = wram_idx;
         oam_waddr    = oam_idx;
         unused_waddr = unused_idx;
         io_waddr     = io_idx;
         hram_waddr   = hram_idx;
      end
   end

   hcmb_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
      .clock(clock), .we(vram_we), .waddr(vram_waddr), .wdata(ram_wdata),
      .raddr(vram_idx), .rdata(vram_rd));

   hcmb_ram #(.WIDTH(8), .DEPTH(WRAM_BYTES)) u_wram (
      .clock(clock), .we(wram_we), .waddr(wram_waddr), .wdata(ram_wdata),
      .raddr(wram_idx), .rdata(wram_rd));

   hcmb_ram #(.WIDTH(8), .DEPTH(hcmb_pkg::SPRITE_BYTES)) u_oam (
      .clock(clock), .we(oam_we), .waddr(oam_waddr), .wdata(ram_wdata),
      .raddr(oam_idx), .rdata(oam_rd));

   hcmb_ram #(.WIDTH(8), .DEPTH(hcmb_pkg::UNUSED_BYTES)) u_unused (
      .clock(clock), .we(unused_we), .waddr(unused_waddr), .wdata(ram_wdata),
      .raddr(unused_idx), .rdata(unused_rd));

   hcmb_ram #(.WIDTH(8), .DEPTH(hcmb_pkg::IO_BYTES)) u_io (
      .clock(clock), .we(io_we), .waddr(io_waddr), .wdata(io_wdata),
      .raddr(io_idx), .rdata(io_rd));

   hcmb_ram #(.WIDTH(8), .DEPTH(hcmb_pkg::HRAM_BYTES)) u_hram (
      .clock(clock), .we(hram_we), .waddr(hram_waddr), .wdata(ram_wdata),
      .raddr(hram_idx), .rdata(hram_rd));

   // decode: where the read byte comes from and what the cartridge sees
   always_comb begin
      s1_src_in  = hcmb_pkg::SRC_HOLD;
      s1_hold_in = 8'h00;
      s1_op_in   = hcmb_pkg::CART_NONE;
      unique case (region)
         hcmb_pkg::RGN_CART: begin
            s1_op_in   = wr ? hcmb_pkg::CART_MAPPER : hcmb_pkg::CART_READ;
            s1_hold_in = req_cart_read_data;
         end
         hcmb_pkg::RGN_XRAM: begin
            if (ext_present_ff) begin
               s1_op_in   = wr ? hcmb_pkg::CART_XWRITE : hcmb_pkg::CART_READ;
               s1_hold_in = req_cart_read_data;
            end else begin
               s1_hold_in = hcmb_pkg::BYTE_ONES;
            end
         end
         hcmb_pkg::RGN_VRAM:   s1_src_in = hcmb_pkg::SRC_VRAM;
         hcmb_pkg::RGN_WRAM:   s1_src_in = hcmb_pkg::SRC_WRAM;
         hcmb_pkg::RGN_OAM:    s1_src_in = hcmb_pkg::SRC_OAM;
         hcmb_pkg::RGN_UNUSED: s1_src_in = hcmb_pkg::SRC_UNUSED;
         hcmb_pkg::RGN_HRAM:   s1_src_in = hcmb_pkg::SRC_HRAM;
         hcmb_pkg::RGN_IO: begin
            if (reg_hit) s1_hold_in = reg_data;
            else         s1_src_in  = hcmb_pkg::SRC_IO;
         end
         hcmb_pkg::RGN_IE:     s1_hold_in = reg_data;
         default:              s1_src_in  = hcmb_pkg::SRC_HOLD;
      endcase
      // writes return zero
      if (wr) begin
         s1_src_in  = hcmb_pkg::SRC_HOLD;
         s1_hold_in = 8'h00;
      end
   end

   // read byte once the store data is out
   always_comb begin
      unique case (s1_src_ff)
         hcmb_pkg::SRC_VRAM:   rsp_read_in = vram_rd;
         hcmb_pkg::SRC_WRAM:   rsp_read_in = wram_rd;
         hcmb_pkg::SRC_OAM:    rsp_read_in = oam_rd;
         hcmb_pkg::SRC_UNUSED: rsp_read_in = unused_rd;
         hcmb_pkg::SRC_IO:     rsp_read_in = io_rd;
         hcmb_pkg::SRC_HRAM:   rsp_read_in = hram_rd;
         default:              rsp_read_in = s1_hold_ff;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= 1'b1;
         cnt_ff         <= '0;
         ext_present_ff <= 1'b1;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clear_ff     <= clear_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= accept;
         rsp_valid_ff <= s1_valid_ff;
         if (csr_write_enable) begin
            ext_present_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_src_ff   <= s1_src_in;
      s1_hold_ff  <= s1_hold_in;
      s1_op_ff    <= s1_op_in;
      s1_addr_ff  <= (s1_op_in != hcmb_pkg::CART_NONE) ? req_address : 16'h0000;
      s1_wdata_ff <= ((s1_op_in == hcmb_pkg::CART_MAPPER) ||
                      (s1_op_in == hcmb_pkg::CART_XWRITE)) ? req_write_data : 8'h00;
      rsp_read_ff  <= rsp_read_in;
      rsp_op_ff    <= s1_op_ff;
      rsp_addr_ff  <= s1_addr_ff;
      rsp_wdata_ff <= s1_wdata_ff;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_read_data       = rsp_read_ff;
   assign rsp_cart_op         = rsp_op_ff;
   assign rsp_cart_address    = rsp_addr_ff;
   assign rsp_cart_write_data = rsp_wdata_ff;

endmodule

// ===== hw/rtl/hcmb_checker.sv =====
module hcmb_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [7:0]  rsp_read_data,
   input logic [1:0]  rsp_cart_op,
   input logic [15:0] rsp_cart_address,
   input logic [7:0]  rsp_cart_write_data
);

   // every accepted transfer gives a result after the request and result registers
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted transfer gave no result");

   // no result without an accepted transfer
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without transfer");

   // once the clear sweep ends the block stays ready
   a_busy_once: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !busy)
      else $error("busy rose without reset");

   // no cartridge traffic means no forwarded address or data
   a_cart_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_cart_op == hcmb_pkg::CART_NONE) |->
         (rsp_cart_address == 16'h0000 && rsp_cart_write_data == 8'h00))
      else $error("cartridge fields set without operation");

   // a write forwarded to the cartridge returns no read byte
   a_cart_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_cart_op == hcmb_pkg::CART_MAPPER ||
                     rsp_cart_op == hcmb_pkg::CART_XWRITE)) |-> rsp_read_data == 8'h00)
      else $error("read byte on cartridge write");

endmodule

bind handheld_console_memory_bus hcmb_checker u_hcmb_checker (.*);
